// File: rtl/core/tlgr_pkg.sv
// Shared types, constants and the 5x7 font table of the text line glyph renderer.
`default_nettype none

package tlgr_pkg;

    // Input opcodes, carried on the slave-side tuser.
    typedef enum logic [1:0] {
        OP_START      = 2'd0,
        OP_BEGIN_LINE = 2'd1,
        OP_TEXT       = 2'd2,
        OP_END_LINE   = 2'd3
    } t_opcode;

    // Configuration register indexes, taken from the word address.
    typedef enum logic {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } t_reg_index;

    localparam int unsigned COORD_W   = 12;
    localparam int unsigned POS_W     = 16;
    localparam int unsigned COLOR_W   = 16;
    localparam int unsigned GLYPH_ROWS = 7;
    localparam int unsigned GLYPH_COLS = 5;

    localparam logic [POS_W-1:0]   CELL_WIDTH     = 16'd8;
    localparam logic [POS_W-1:0]   LINE_PITCH     = 16'd14;
    localparam logic [COORD_W-1:0] MAX_FILL_WIDTH = 12'd160;
    localparam logic [COORD_W-1:0] GLYPH_X_OFFSET = 12'd1;
    localparam logic [COORD_W-1:0] GLYPH_Y_OFFSET = 12'd2;
    localparam logic [COLOR_W-1:0] COLOR_WHITE    = 16'hFFFF;
    localparam logic [COLOR_W-1:0] COLOR_BLACK    = 16'h0000;

    localparam logic [COORD_W-1:0] RESET_SCREEN_WIDTH  = 12'd160;
    localparam logic [COORD_W-1:0] RESET_SCREEN_HEIGHT = 12'd128;

    // One glyph: element [row] holds a row, bit 4 is the leftmost pixel.
    typedef logic [0:GLYPH_ROWS-1][GLYPH_COLS-1:0] t_glyph;

    // Font lookup. Anything not in the font, including control and high bytes, draws '?'.
    function automatic t_glyph font_glyph(input logic [7:0] code);
        t_glyph g;
        unique case (code)
            " ": g = {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00};
            "-": g = {5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00};
            "0": g = {5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E};
            "1": g = {5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E};
            "2": g = {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F};
            "3": g = {5'h1E,5'h01,5'h01,5'h0E,5'h01,5'h01,5'h1E};
            "4": g = {5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02};
            "5": g = {5'h1F,5'h10,5'h10,5'h1E,5'h01,5'h01,5'h1E};
            "6": g = {5'h07,5'h08,5'h10,5'h1E,5'h11,5'h11,5'h0E};
            "7": g = {5'h1F,5'h01,5'h01,5'h02,5'h04,5'h08,5'h08};
            "8": g = {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E};
            "9": g = {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h02,5'h1C};
            "A": g = {5'h04,5'h0A,5'h11,5'h11,5'h1F,5'h11,5'h11};
            "B": g = {5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E};
            "C": g = {5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E};
            "D": g = {5'h1E,5'h12,5'h11,5'h11,5'h11,5'h12,5'h1E};
            "E": g = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F};
            "F": g = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10};
            "G": g = {5'h0E,5'h11,5'h10,5'h13,5'h11,5'h11,5'h0F};
            "H": g = {5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11};
            "I": g = {5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E};
            "J": g = {5'h01,5'h01,5'h01,5'h01,5'h11,5'h11,5'h0E};
            "K": g = {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11};
            "L": g = {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F};
            "M": g = {5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11};
            "N": g = {5'h11,5'h11,5'h19,5'h15,5'h13,5'h11,5'h11};
            "O": g = {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
            "P": g = {5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10};
            "Q": g = {5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D};
            "R": g = {5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11};
            "S": g = {5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E};
            "T": g = {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04};
            "U": g = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
            "V": g = {5'h11,5'h11,5'h11,5'h11,5'h0A,5'h0A,5'h04};
            "W": g = {5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h0A};
            "X": g = {5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11};
            "Y": g = {5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04};
            "Z": g = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F};
            "a": g = {5'h00,5'h00,5'h0E,5'h01,5'h0F,5'h11,5'h0F};
            "b": g = {5'h10,5'h10,5'h1E,5'h11,5'h11,5'h11,5'h1E};
            "c": g = {5'h00,5'h00,5'h0E,5'h11,5'h10,5'h11,5'h0E};
            "d": g = {5'h01,5'h01,5'h0F,5'h11,5'h11,5'h11,5'h0F};
            "e": g = {5'h00,5'h00,5'h0E,5'h11,5'h1F,5'h10,5'h0E};
            "f": g = {5'h06,5'h08,5'h08,5'h1E,5'h08,5'h08,5'h08};
            "g": g = {5'h00,5'h0F,5'h11,5'h11,5'h0F,5'h01,5'h0E};
            "h": g = {5'h10,5'h10,5'h1E,5'h11,5'h11,5'h11,5'h11};
            "i": g = {5'h04,5'h00,5'h0C,5'h04,5'h04,5'h04,5'h0E};
            "j": g = {5'h02,5'h00,5'h06,5'h02,5'h02,5'h12,5'h0C};
            "k": g = {5'h10,5'h10,5'h12,5'h14,5'h18,5'h14,5'h12};
            "l": g = {5'h0C,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E};
            "m": g = {5'h00,5'h00,5'h1A,5'h15,5'h15,5'h15,5'h15};
            "n": g = {5'h00,5'h00,5'h1E,5'h11,5'h11,5'h11,5'h11};
            "o": g = {5'h00,5'h00,5'h0E,5'h11,5'h11,5'h11,5'h0E};
            "p": g = {5'h00,5'h00,5'h1E,5'h11,5'h1E,5'h10,5'h10};
            "q": g = {5'h00,5'h00,5'h0F,5'h11,5'h0F,5'h01,5'h01};
            "r": g = {5'h00,5'h00,5'h16,5'h19,5'h10,5'h10,5'h10};
            "s": g = {5'h00,5'h00,5'h0F,5'h10,5'h0E,5'h01,5'h1E};
            "t": g = {5'h08,5'h08,5'h1E,5'h08,5'h08,5'h08,5'h06};
            "u": g = {5'h00,5'h00,5'h11,5'h11,5'h11,5'h13,5'h0D};
            "v": g = {5'h00,5'h00,5'h11,5'h11,5'h11,5'h0A,5'h04};
            "w": g = {5'h00,5'h00,5'h11,5'h11,5'h15,5'h15,5'h0A};
            "x": g = {5'h00,5'h00,5'h11,5'h0A,5'h04,5'h0A,5'h11};
            "y": g = {5'h00,5'h00,5'h11,5'h11,5'h0F,5'h01,5'h0E};
            "z": g = {5'h00,5'h00,5'h1F,5'h02,5'h04,5'h08,5'h1F};
            default: g = {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h00,5'h04};
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/text_line_glyph_renderer.sv
// Text line glyph renderer: opcode and text byte stream in, rectangle fill commands out.
`default_nettype none

// One input word is taken per cycle whenever the fill queue is free. Start display
// and begin line give at most one clear fill each; a text byte gives one 1x1 black
// fill per lit pixel of its 5x7 glyph, so a visible character issues 5 to 20 fill words
// in turn, and the next word is accepted in the cycle its last fill is issued. Words
// that cause no fill (end line, space, ignored text) load no job and do not hold the
// input. Throughput is set by the output channel: one fill word per cycle while the
// receiver is ready. The state update for a word happens when it is accepted.
module text_line_glyph_renderer
    import tlgr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] opcode
    // Fill command stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [11:0] rect_x, [23:12] rect_y,
                                             // [35:24] rect_width, [47:36] rect_height,
                                             // [63:48] fill_color
    output logic             m_axis_tlast    // last
);

    // Configuration and drawing state
    logic [COORD_W-1:0] r_screen_width, r_screen_height;
    logic [POS_W-1:0]   r_cursor_row, n_cursor_row;
    logic [POS_W-1:0]   r_pen_column, n_pen_column;
    logic               r_started, n_started;
    logic               r_line_stopped, n_line_stopped;
    logic               r_skipping, n_skipping;

    // Pending job: one clear fill or a glyph bitmap still to be walked
    logic               r_job_valid;
    logic               r_job_clear, n_job_clear;
    t_glyph             r_job_mask, n_job_mask;
    logic [COORD_W-1:0] r_job_x, n_job_x;
    logic [COORD_W-1:0] r_job_y, n_job_y;
    logic [COORD_W-1:0] r_job_w, n_job_w;
    logic [COORD_W-1:0] r_job_h, n_job_h;
    logic               n_job_load;

    // Output register
    logic               r_out_valid;
    logic [63:0]        r_out_data;
    logic               r_out_last;

    logic               cfg_write;
    logic               in_accept;
    logic               out_free;
    logic               emit;
    logic               job_done;
    logic               active;
    t_opcode            opcode;
    logic [7:0]         char_byte;
    logic [2:0]         sel_gx, sel_gy;
    logic               sel_found;
    t_glyph             rest_mask;
    logic [COORD_W-1:0] fill_x, fill_y, fill_w, fill_h;
    logic [COLOR_W-1:0] fill_color;
    logic [POS_W:0]     row_reach, pen_reach;
    logic [POS_W-1:0]   line_row;

    assign opcode    = t_opcode'(s_axis_tuser);
    assign char_byte = s_axis_tdata;

    // Configuration port: written in the access phase, always ready
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= RESET_SCREEN_WIDTH;
            r_screen_height <= RESET_SCREEN_HEIGHT;
        end else if (cfg_write) begin
            unique case (t_reg_index'(paddr[2]))
                REG_SCREEN_WIDTH:  r_screen_width  <= pwdata[COORD_W-1:0];
                REG_SCREEN_HEIGHT: r_screen_height <= pwdata[COORD_W-1:0];
                default:           r_screen_width  <= r_screen_width;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_index'(paddr[2]))
            REG_SCREEN_WIDTH:  prdata = {20'd0, r_screen_width};
            REG_SCREEN_HEIGHT: prdata = {20'd0, r_screen_height};
            default:           prdata = 32'd0;
        endcase
    end

    // Find the first lit pixel of the pending glyph, rows first, left to right
    always_comb begin
        sel_found = 1'b0;
        sel_gx    = 3'd0;
        sel_gy    = 3'd0;
        for (int gy = 0; gy < GLYPH_ROWS; gy++) begin
            for (int gx = 0; gx < GLYPH_COLS; gx++) begin
                if (!sel_found && r_job_mask[gy][GLYPH_COLS-1-gx]) begin
                    sel_found = 1'b1;
                    sel_gx    = 3'(gx);
                    sel_gy    = 3'(gy);
                end
            end
        end
        rest_mask = r_job_mask;
        rest_mask[sel_gy][3'(GLYPH_COLS-1) - sel_gx] = 1'b0;
    end

    // Fill word for the current job
    always_comb begin
        if (r_job_clear) begin
            fill_x     = r_job_x;
            fill_y     = r_job_y;
            fill_w     = r_job_w;
            fill_h     = r_job_h;
            fill_color = COLOR_WHITE;
        end else begin
            fill_x     = r_job_x + GLYPH_X_OFFSET + COORD_W'(sel_gx);
            fill_y     = r_job_y + GLYPH_Y_OFFSET + COORD_W'(sel_gy);
            fill_w     = 12'd1;
            fill_h     = 12'd1;
            fill_color = COLOR_BLACK;
        end
    end

    // Handshake: a new word is taken once the pending job issues its last fill
    assign out_free      = !r_out_valid || m_axis_tready;
    assign emit          = r_job_valid && out_free;
    assign job_done      = emit && (r_job_clear || (rest_mask == '0));
    assign s_axis_tready = !r_job_valid || job_done;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Decode of the incoming word: state update and the job it raises
    assign active    = r_started && (r_screen_width != '0) && (r_screen_height != '0);
    assign row_reach = {1'b0, r_cursor_row} + {1'b0, LINE_PITCH};
    assign pen_reach = {1'b0, r_pen_column} + {1'b0, CELL_WIDTH};
    assign line_row  = (row_reach > (POS_W+1)'(r_screen_height)) ? '0 : r_cursor_row;

    always_comb begin
        n_cursor_row   = r_cursor_row;
        n_pen_column   = r_pen_column;
        n_started      = r_started;
        n_line_stopped = r_line_stopped;
        n_skipping     = r_skipping;
        n_job_load     = 1'b0;
        n_job_clear    = 1'b1;
        n_job_mask     = '0;
        n_job_x        = '0;
        n_job_y        = '0;
        n_job_w        = r_screen_width;
        n_job_h        = r_screen_height;
        case (opcode)
            OP_START: begin
                if (!r_started) begin
                    n_started    = 1'b1;
                    n_cursor_row = '0;
                    n_job_load   = (r_screen_width != '0) && (r_screen_height != '0)
                                   && (r_screen_width <= MAX_FILL_WIDTH);
                end
            end
            OP_BEGIN_LINE: begin
                n_skipping = 1'b0;
                if (!active) begin
                    n_line_stopped = 1'b1;
                end else begin
                    n_cursor_row   = line_row;
                    n_pen_column   = '0;
                    n_line_stopped = 1'b0;
                    n_job_load     = (r_screen_width <= MAX_FILL_WIDTH);
                    n_job_y        = line_row[COORD_W-1:0];
                    n_job_h        = LINE_PITCH[COORD_W-1:0];
                end
            end
            OP_END_LINE: begin
                n_skipping     = 1'b0;
                n_line_stopped = 1'b1;
                if (active) begin
                    n_cursor_row = row_reach[POS_W-1:0];
                end
            end
            default: begin
                // Text byte; continuation bytes after a high byte are swallowed
                if (active && !r_line_stopped
                        && !(r_skipping && (char_byte[7:6] == 2'b10))) begin
                    n_skipping = char_byte[7];
                    if (pen_reach > (POS_W+1)'(r_screen_width)) begin
                        n_line_stopped = 1'b1;
                    end else begin
                        n_pen_column = pen_reach[POS_W-1:0];
                        n_job_clear  = 1'b0;
                        n_job_mask   = font_glyph(char_byte);
                        n_job_x      = r_pen_column[COORD_W-1:0];
                        n_job_y      = r_cursor_row[COORD_W-1:0];
                        n_job_load   = (n_job_mask != '0);
                    end
                end
            end
        endcase
    end

    // Drawing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_row   <= '0;
            r_pen_column   <= '0;
            r_started      <= 1'b0;
            r_line_stopped <= 1'b0;
            r_skipping     <= 1'b0;
        end else if (in_accept) begin
            r_cursor_row   <= n_cursor_row;
            r_pen_column   <= n_pen_column;
            r_started      <= n_started;
            r_line_stopped <= n_line_stopped;
            r_skipping     <= n_skipping;
        end
    end

    // Job register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
        end else if (in_accept) begin
            r_job_valid <= n_job_load;
        end else if (job_done) begin
            r_job_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_job_clear <= n_job_clear;
            r_job_mask  <= n_job_mask;
            r_job_x     <= n_job_x;
            r_job_y     <= n_job_y;
            r_job_w     <= n_job_w;
            r_job_h     <= n_job_h;
        end else if (emit) begin
            r_job_mask  <= rest_mask;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= {fill_color, fill_h, fill_w, fill_y, fill_x};
            r_out_last <= job_done;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // A glyph job always holds at least one lit pixel while it issues fills
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !r_job_clear) |-> sel_found)
        else $error("glyph job issued with no lit pixel");

    // Black fills are single pixels
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[63:48] == COLOR_BLACK))
            |-> (m_axis_tdata[35:24] == 12'd1) && (m_axis_tdata[47:36] == 12'd1))
        else $error("black fill larger than one pixel");

    // Once started, the display stays started until reset
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_started))
        else $error("started flag dropped");

    // A job that finishes frees the input side in the same cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_job_valid) |-> job_done)
        else $error("input accepted over a pending job");

endmodule

`default_nettype wire

// File: tb/tb_text_line_glyph_renderer.sv
// Self-checking testbench for the text line glyph renderer: directed and random word streams.
`default_nettype none

module tb_text_line_glyph_renderer;
    import tlgr_pkg::*;

    // One word on the text stream and one fill command on the output stream.
    typedef struct packed {
        t_opcode     op;
        logic [7:0]  ch;
    } t_text_word;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [11:0] w;
        logic [11:0] h;
        logic [15:0] colour;
        logic        last;
    } t_fill_cmd;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 16;
    localparam int PHASE_WORDS  = 50;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] char_byte
    logic [1:0]  s_axis_tuser = '0;   // [1:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;        // [11:0] x, [23:12] y, [35:24] width,
                                      // [47:36] height, [63:48] colour
    logic        m_axis_tlast;

    // Words waiting to be offered, and fill commands still owed by the block.
    t_text_word  pending_words [$];
    t_fill_cmd   expected_fills [$];

    // Font of the glyph predictor: bits [34:30] hold the top row, MSB leftmost.
    logic [34:0] font_bits [0:255];
    bit          font_known [0:255];
    string       glyph_chars =
        "-0123456789?ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

    // Predictor copy of the registers and of the drawing state.
    logic [11:0] scr_width = RESET_SCREEN_WIDTH;
    logic [11:0] scr_height = RESET_SCREEN_HEIGHT;
    logic [15:0] row_pos = '0;
    logic [15:0] pen_pos = '0;
    bit          display_on = 1'b0;
    bit          line_closed = 1'b0;
    bit          skip_cont = 1'b0;

    bit          in_fire = 1'b0;
    bit          out_fire = 1'b0;
    bit          idle_on = 1'b1;
    int          send_gap = 0;
    int          rx_wait = 0;
    int          hold_wanted = 0;
    int          hold_served = 0;
    int          quiet_cycles = 0;
    int          errors = 0;
    int          queued_words = 0;
    int          words_taken = 0;
    int          clears_seen = 0;
    int          pixels_seen = 0;
    int          reg_writes = 0;

    text_line_glyph_renderer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic void put_glyph(input logic [7:0] c, input logic [34:0] rows);
        font_bits[c] = rows;
        font_known[c] = 1'b1;
    endfunction

    function automatic void load_font();
        for (int k = 0; k < 256; k++) begin
            font_bits[k] = '0;
            font_known[k] = 1'b0;
        end
        put_glyph(" ", {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00});
        put_glyph("-", {5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00});
        put_glyph("0", {5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E});
        put_glyph("1", {5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E});
        put_glyph("2", {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F});
        put_glyph("3", {5'h1E,5'h01,5'h01,5'h0E,5'h01,5'h01,5'h1E});
        put_glyph("4", {5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02});
        put_glyph("5", {5'h1F,5'h10,5'h10,5'h1E,5'h01,5'h01,5'h1E});
        put_glyph("6", {5'h07,5'h08,5'h10,5'h1E,5'h11,5'h11,5'h0E});
        put_glyph("7", {5'h1F,5'h01,5'h01,5'h02,5'h04,5'h08,5'h08});
        put_glyph("8", {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E});
        put_glyph("9", {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h02,5'h1C});
        put_glyph("?", {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h00,5'h04});
        put_glyph("A", {5'h04,5'h0A,5'h11,5'h11,5'h1F,5'h11,5'h11});
        put_glyph("B", {5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E});
        put_glyph("C", {5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E});
        put_glyph("D", {5'h1E,5'h12,5'h11,5'h11,5'h11,5'h12,5'h1E});
        put_glyph("E", {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F});
        put_glyph("F", {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10});
        put_glyph("G", {5'h0E,5'h11,5'h10,5'h13,5'h11,5'h11,5'h0F});
        put_glyph("H", {5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11});
        put_glyph("I", {5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E});
        put_glyph("J", {5'h01,5'h01,5'h01,5'h01,5'h11,5'h11,5'h0E});
        put_glyph("K", {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11});
        put_glyph("L", {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F});
        put_glyph("M", {5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11});
        put_glyph("N", {5'h11,5'h11,5'h19,5'h15,5'h13,5'h11,5'h11});
        put_glyph("O", {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E});
        put_glyph("P", {5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10});
        put_glyph("Q", {5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D});
        put_glyph("R", {5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11});
        put_glyph("S", {5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E});
        put_glyph("T", {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04});
        put_glyph("U", {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E});
        put_glyph("V", {5'h11,5'h11,5'h11,5'h11,5'h0A,5'h0A,5'h04});
        put_glyph("W", {5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h0A});
        put_glyph("X", {5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11});
        put_glyph("Y", {5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04});
        put_glyph("Z", {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F});
        put_glyph("a", {5'h00,5'h00,5'h0E,5'h01,5'h0F,5'h11,5'h0F});
        put_glyph("b", {5'h10,5'h10,5'h1E,5'h11,5'h11,5'h11,5'h1E});
        put_glyph("c", {5'h00,5'h00,5'h0E,5'h11,5'h10,5'h11,5'h0E});
        put_glyph("d", {5'h01,5'h01,5'h0F,5'h11,5'h11,5'h11,5'h0F});
        put_glyph("e", {5'h00,5'h00,5'h0E,5'h11,5'h1F,5'h10,5'h0E});
        put_glyph("f", {5'h06,5'h08,5'h08,5'h1E,5'h08,5'h08,5'h08});
        put_glyph("g", {5'h00,5'h0F,5'h11,5'h11,5'h0F,5'h01,5'h0E});
        put_glyph("h", {5'h10,5'h10,5'h1E,5'h11,5'h11,5'h11,5'h11});
        put_glyph("i", {5'h04,5'h00,5'h0C,5'h04,5'h04,5'h04,5'h0E});
        put_glyph("j", {5'h02,5'h00,5'h06,5'h02,5'h02,5'h12,5'h0C});
        put_glyph("k", {5'h10,5'h10,5'h12,5'h14,5'h18,5'h14,5'h12});
        put_glyph("l", {5'h0C,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E});
        put_glyph("m", {5'h00,5'h00,5'h1A,5'h15,5'h15,5'h15,5'h15});
        put_glyph("n", {5'h00,5'h00,5'h1E,5'h11,5'h11,5'h11,5'h11});
        put_glyph("o", {5'h00,5'h00,5'h0E,5'h11,5'h11,5'h11,5'h0E});
        put_glyph("p", {5'h00,5'h00,5'h1E,5'h11,5'h1E,5'h10,5'h10});
        put_glyph("q", {5'h00,5'h00,5'h0F,5'h11,5'h0F,5'h01,5'h01});
        put_glyph("r", {5'h00,5'h00,5'h16,5'h19,5'h10,5'h10,5'h10});
        put_glyph("s", {5'h00,5'h00,5'h0F,5'h10,5'h0E,5'h01,5'h1E});
        put_glyph("t", {5'h08,5'h08,5'h1E,5'h08,5'h08,5'h08,5'h06});
        put_glyph("u", {5'h00,5'h00,5'h11,5'h11,5'h11,5'h13,5'h0D});
        put_glyph("v", {5'h00,5'h00,5'h11,5'h11,5'h11,5'h0A,5'h04});
        put_glyph("w", {5'h00,5'h00,5'h11,5'h11,5'h15,5'h15,5'h0A});
        put_glyph("x", {5'h00,5'h00,5'h11,5'h0A,5'h04,5'h0A,5'h11});
        put_glyph("y", {5'h00,5'h00,5'h11,5'h11,5'h0F,5'h01,5'h0E});
        put_glyph("z", {5'h00,5'h00,5'h1F,5'h02,5'h04,5'h08,5'h1F});
    endfunction

    // Coordinates and sizes are cut to 12 bits on the way out.
    function automatic void queue_fill(input int unsigned x, input int unsigned y,
                                       input int unsigned w, input int unsigned h,
                                       input logic [15:0] colour);
        t_fill_cmd f;
        f.x = x[11:0];
        f.y = y[11:0];
        f.w = w[11:0];
        f.h = h[11:0];
        f.colour = colour;
        f.last = 1'b0;
        expected_fills.push_back(f);
    endfunction

    // Works out the fill commands one accepted word causes and updates the drawing state.
    function automatic void predict_fills(input t_opcode op, input logic [7:0] ch);
        int unsigned first_fill;
        int unsigned reach;
        bit          active;
        logic [34:0] glyph;
        t_fill_cmd   tail;
        first_fill = expected_fills.size();
        active = display_on && scr_width != 0 && scr_height != 0;
        case (op)
            OP_START: begin
                if (!display_on) begin
                    display_on = 1'b1;
                    row_pos = '0;
                    if (scr_width != 0 && scr_height != 0 && scr_width <= MAX_FILL_WIDTH)
                        queue_fill(0, 0, 32'(scr_width), 32'(scr_height), COLOR_WHITE);
                end
            end
            OP_BEGIN_LINE: begin
                skip_cont = 1'b0;
                if (!active) begin
                    line_closed = 1'b1;
                end else begin
                    reach = 32'(row_pos);
                    reach = reach + 32'(LINE_PITCH);
                    if (reach > 32'(scr_height))
                        row_pos = '0;
                    if (scr_width <= MAX_FILL_WIDTH)
                        queue_fill(0, 32'(row_pos), 32'(scr_width), 32'(LINE_PITCH),
                                   COLOR_WHITE);
                    pen_pos = '0;
                    line_closed = 1'b0;
                end
            end
            OP_END_LINE: begin
                skip_cont = 1'b0;
                line_closed = 1'b1;
                if (active)
                    row_pos = row_pos + LINE_PITCH;
            end
            default: begin
                // Continuation bytes after a high byte are swallowed silently.
                if (active && !line_closed && !(skip_cont && ch[7:6] == 2'b10)) begin
                    skip_cont = 1'b0;
                    if (ch < 8'h20 || ch > 8'h7E) begin
                        glyph = font_bits["?"];
                        skip_cont = ch[7];
                    end else if (font_known[ch]) begin
                        glyph = font_bits[ch];
                    end else begin
                        glyph = font_bits["?"];
                    end
                    reach = 32'(pen_pos);
                    reach = reach + 32'(CELL_WIDTH);
                    if (reach > 32'(scr_width)) begin
                        line_closed = 1'b1;
                    end else begin
                        for (int gy = 0; gy < 7; gy++)
                            for (int gx = 0; gx < 5; gx++)
                                if (glyph[(6 - gy) * 5 + 4 - gx])
                                    queue_fill(32'(pen_pos) + 32'(GLYPH_X_OFFSET) + 32'(gx),
                                               32'(row_pos) + 32'(GLYPH_Y_OFFSET) + 32'(gy),
                                               1, 1, COLOR_BLACK);
                        pen_pos = pen_pos + CELL_WIDTH;
                    end
                end
            end
        endcase
        if (expected_fills.size() > first_fill) begin
            tail = expected_fills.pop_back();
            tail.last = 1'b1;
            expected_fills.push_back(tail);
        end
    endfunction

    function automatic void queue_word(input t_opcode op, input logic [7:0] ch);
        t_text_word w;
        w.op = op;
        w.ch = ch;
        pending_words.push_back(w);
        queued_words++;
    endfunction

    // Mostly font characters, with spaces, high bytes and anything else mixed in.
    function automatic logic [7:0] pick_text_byte();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 66)
            return glyph_chars[$urandom_range(0, glyph_chars.len() - 1)];
        if (sel < 76)
            return " ";
        if (sel < 86)
            return 8'($urandom_range(128, 255));
        return 8'($urandom_range(0, 255));
    endfunction

    // A line with random content, mostly closed by end line; high bytes often trail continuations.
    function automatic void queue_line(input int max_len);
        int         n;
        logic [7:0] c;
        queue_word(OP_BEGIN_LINE, 8'($urandom));
        n = $urandom_range(0, max_len);
        for (int k = 0; k < n; k++) begin
            c = pick_text_byte();
            queue_word(OP_TEXT, c);
            if (c[7] && $urandom_range(0, 1))
                repeat ($urandom_range(1, 3))
                    queue_word(OP_TEXT, 8'($urandom_range(128, 191)));
        end
        if ($urandom_range(0, 9) != 0)
            queue_word(OP_END_LINE, 8'($urandom));
    endfunction

    // Sender: offers the next pending word, with short random gaps between words while idling is on.
    always @(negedge i_clk) begin : sender
        t_text_word w;
        if (!s_axis_tvalid || in_fire) begin
            if (send_gap != 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                w = pending_words.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= w.ch;
                s_axis_tuser <= w.op;
                if (idle_on && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 3);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: short random stalls while idling is on, and a long hold-off when one is requested.
    always @(negedge i_clk) begin : receiver
        if (hold_served != hold_wanted) begin
            hold_served = hold_wanted;
            rx_wait = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 6) == 0)
                rx_wait = $urandom_range(1, 3);
        end
    end

    // Predicts on every accepted text word and checks every accepted fill word.
    always @(posedge i_clk) begin : monitor
        t_fill_cmd got;
        t_fill_cmd want;
        in_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        out_fire = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (in_fire) begin
            predict_fills(t_opcode'(s_axis_tuser), s_axis_tdata);
            words_taken++;
        end
        if (out_fire) begin
            got.x = m_axis_tdata[11:0];
            got.y = m_axis_tdata[23:12];
            got.w = m_axis_tdata[35:24];
            got.h = m_axis_tdata[47:36];
            got.colour = m_axis_tdata[63:48];
            got.last = m_axis_tlast;
            if (got.colour == COLOR_WHITE)
                clears_seen++;
            else
                pixels_seen++;
            if (expected_fills.size() == 0) begin
                errors++;
                $display("%0t: unexpected fill, expected none, actual x=%0d y=%0d w=%0d h=%0d colour=%h last=%0d",
                         $time, got.x, got.y, got.w, got.h, got.colour, got.last);
            end else begin
                want = expected_fills.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: fill mismatch, expected x=%0d y=%0d w=%0d h=%0d colour=%h last=%0d",
                             $time, want.x, want.y, want.w, want.h, want.colour, want.last);
                    $display("%0t:                  actual x=%0d y=%0d w=%0d h=%0d colour=%h last=%0d",
                             $time, got.x, got.y, got.w, got.h, got.colour, got.last);
                end
            end
        end
        if (in_fire || out_fire)
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    initial begin : watchdog
        while (quiet_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("%0t: no word moved for %0d cycles, %0d fills outstanding",
                 $time, STALL_LIMIT, expected_fills.size());
        $display("tb_text_line_glyph_renderer: done, errors");
        $finish;
    end

    // Waits until every word is taken and every fill has come, then lets the block settle.
    task automatic wait_idle();
        while (pending_words.size() != 0 || s_axis_tvalid || expected_fills.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Writes a register over APB, then reads it back.
    task automatic set_reg(input t_reg_index idx, input logic [11:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {20'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (idx == REG_SCREEN_WIDTH)
            scr_width = value;
        else
            scr_height = value;
        reg_writes++;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {20'd0, value}) begin
            errors++;
            $display("%0t: register %0d read back, expected %h, actual %h",
                     $time, idx, {20'd0, value}, prdata);
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin : stimulus
        int unsigned phase_w [8];
        int unsigned phase_h [8];
        int          first_word;
        int          max_len;

        phase_w = '{160, 96, 4095, 161, 40, 8, 1, 160};
        phase_h = '{128, 60, 4095, 28, 4095, 13, 1, 128};
        load_font();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: text before start, repeated start, text before the first line,
        // every glyph class, high bytes with continuations, and text after end line.
        queue_word(OP_TEXT, "A");
        queue_word(OP_START, 8'hFF);
        queue_word(OP_START, 8'h00);
        queue_word(OP_TEXT, "Z");
        queue_word(OP_BEGIN_LINE, 8'hAA);
        queue_word(OP_TEXT, "A");
        queue_word(OP_TEXT, "0");
        queue_word(OP_TEXT, "z");
        queue_word(OP_TEXT, " ");
        queue_word(OP_TEXT, "-");
        queue_word(OP_TEXT, 8'h00);
        queue_word(OP_TEXT, 8'h7F);
        queue_word(OP_TEXT, "~");
        queue_word(OP_TEXT, 8'hFF);
        queue_word(OP_TEXT, 8'h80);
        queue_word(OP_TEXT, 8'hBF);
        queue_word(OP_TEXT, 8'hC3);
        queue_word(OP_TEXT, "A");
        queue_word(OP_END_LINE, 8'h55);
        queue_word(OP_TEXT, "B");
        queue_word(OP_BEGIN_LINE, 8'h00);
        queue_word(OP_TEXT, 8'hE2);
        queue_word(OP_BEGIN_LINE, 8'h00);
        queue_word(OP_TEXT, 8'h80);
        queue_word(OP_END_LINE, 8'h00);
        wait_idle();

        // A line two cells wide: the third character closes it, the fourth is ignored.
        set_reg(REG_SCREEN_WIDTH, 12'd20);
        set_reg(REG_SCREEN_HEIGHT, 12'd14);
        queue_word(OP_BEGIN_LINE, 8'h00);
        queue_word(OP_TEXT, "A");
        queue_word(OP_TEXT, "B");
        queue_word(OP_TEXT, "C");
        queue_word(OP_TEXT, "D");
        queue_word(OP_END_LINE, 8'h00);
        queue_word(OP_BEGIN_LINE, 8'h00);
        wait_idle();

        // Zero width, then zero height: nothing is drawn at all.
        set_reg(REG_SCREEN_WIDTH, 12'd0);
        queue_word(OP_BEGIN_LINE, 8'h00);
        queue_word(OP_TEXT, "A");
        queue_word(OP_END_LINE, 8'h00);
        wait_idle();
        set_reg(REG_SCREEN_WIDTH, 12'd160);
        set_reg(REG_SCREEN_HEIGHT, 12'd0);
        queue_word(OP_BEGIN_LINE, 8'h00);
        queue_word(OP_TEXT, "A");
        queue_word(OP_END_LINE, 8'h00);
        wait_idle();

        // Random lines under several screen sizes; the last phase runs without idling.
        for (int p = 0; p < 8; p++) begin
            set_reg(REG_SCREEN_WIDTH, 12'(phase_w[p]));
            set_reg(REG_SCREEN_HEIGHT, 12'(phase_h[p]));
            idle_on = (p != 7);
            max_len = phase_w[p] / 8 + 3;
            if (max_len > 24)
                max_len = 24;
            first_word = queued_words;
            while (queued_words - first_word < PHASE_WORDS) begin
                if ($urandom_range(0, 6) == 0)
                    queue_word(t_opcode'($urandom_range(0, 3)), 8'($urandom));
                else
                    queue_line(max_len);
            end
            // In the first phase only, the receiver holds off while the sender keeps offering words.
            if (p == 0)
                hold_wanted++;
            wait_idle();
        end

        $display("Covered %0d text words, %0d fills (%0d clears, %0d glyph pixels),",
                 words_taken, clears_seen + pixels_seen, clears_seen, pixels_seen);
        $display("and %0d register writes across sizes from 0 up to 4095.", reg_writes);
        if (errors == 0 && expected_fills.size() == 0)
            $display("tb_text_line_glyph_renderer: done, clean");
        else
            $display("tb_text_line_glyph_renderer: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

// File: text_line_glyph_renderer.f
rtl/core/tlgr_pkg.sv
rtl/core/text_line_glyph_renderer.sv
tb/tb_text_line_glyph_renderer.sv
